// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: whenever cond holds, expect holds too.
`define ASSERT_IMPLIES(label, clk, rst, cond, expect_c) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_c)) \
      else $error("assertion failed: label");
// Next-cycle implication: whenever cond holds, expect holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expect_c) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_c)) \
      else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, expect_c)
`define ASSERT_NEXT(label, clk, rst, cond, expect_c)
`endif
`endif

// ----- rtl/core/cigtrim_pkg.sv -----
`default_nettype none
package cigtrim_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int SYMBOL_BITS         = 8;
   localparam int READ_BITS           = 16;

   localparam logic [SYMBOL_BITS-1:0] CHAR_M    = 8'h4D;
   localparam logic [SYMBOL_BITS-1:0] CHAR_I    = 8'h49;
   localparam logic [SYMBOL_BITS-1:0] CHAR_D    = 8'h44;
   localparam logic [SYMBOL_BITS-1:0] CHAR_S    = 8'h53;
   localparam logic [SYMBOL_BITS-1:0] CHAR_H    = 8'h48;
   localparam logic [SYMBOL_BITS-1:0] CHAR_STAR = 8'h2A;
   localparam logic [SYMBOL_BITS-1:0] CHAR_ZERO = 8'h30;
   localparam logic [SYMBOL_BITS-1:0] CHAR_NINE = 8'h39;

   typedef struct packed {
      logic segment_ended;
      logic at_first_char;
      logic star_cigar;
   } cigtrim_flags_type;

   localparam cigtrim_flags_type FLAGS_RESET = '{
      segment_ended: 1'b0,
      at_first_char: 1'b1,
      star_cigar:    1'b0
   };

endpackage
`default_nettype wire

// ----- rtl/core/cigar_aligned_segment_trim_unit.sv -----
`default_nettype none
// CIGAR aligned-segment trim. One CIGAR character is taken per beat, with the
// read length on every beat; the beat that carries last_char produces one
// result beat (changed, trim_start, new_length), and no other beat produces
// any. The block sustains one character per clock cycle: a character goes
// from the input register through the combinational decode and accumulate
// step into the string state, and a final character's result is written
// to the output register as that character leaves the input register. The
// rate is set by the state update; only a final character waiting behind a
// stalled result register holds up the input side. Counts are LENGTH_BITS
// wide and saturate.
`include "assert_macros.svh"
module cigar_aligned_segment_trim_unit #(
   parameter int LENGTH_BITS = cigtrim_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cigtrim_pkg::SYMBOL_BITS-1:0] req_symbol,
   input  logic                                req_last_char,
   input  logic [cigtrim_pkg::READ_BITS-1:0]   req_read_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_changed,
   output logic [cigtrim_pkg::READ_BITS-1:0]   rsp_trim_start,
   output logic [cigtrim_pkg::READ_BITS-1:0]   rsp_new_length
);
   import cigtrim_pkg::*;

   logic                   s1_valid_ff, s1_valid_in;
   logic [SYMBOL_BITS-1:0] s1_symbol_ff;
   logic                   s1_last_ff;
   logic [READ_BITS-1:0]   s1_read_ff;

   logic [LENGTH_BITS-1:0] digit_count_ff, digit_count_in;
   logic [LENGTH_BITS-1:0] aligned_ff, aligned_in;
   logic [LENGTH_BITS-1:0] skip_ff, skip_in;
   cigtrim_flags_type      flags_ff, flags_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic [READ_BITS-1:0]   rsp_trim_ff, rsp_trim_in;
   logic [READ_BITS-1:0]   rsp_length_ff, rsp_length_in;

   logic out_free;
   logic s1_move;
   logic req_take;

   // Non-final characters never wait on the result side.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_move;
   assign req_take  = req_valid && !req_stall;

   cigtrim_step #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_step (
      .symbol              (s1_symbol_ff),
      .last_char           (s1_last_ff),
      .read_length         (s1_read_ff),
      .digit_count         (digit_count_ff),
      .aligned_length      (aligned_ff),
      .start_skip          (skip_ff),
      .flags               (flags_ff),
      .digit_count_next    (digit_count_in),
      .aligned_length_next (aligned_in),
      .start_skip_next     (skip_in),
      .flags_next          (flags_in),
      .changed             (rsp_changed_in),
      .trim_start          (rsp_trim_in),
      .new_length          (rsp_length_in)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_move && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         digit_count_ff <= '0;
         aligned_ff     <= '0;
         skip_ff        <= '0;
         flags_ff       <= FLAGS_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            digit_count_ff <= digit_count_in;
            aligned_ff     <= aligned_in;
            skip_ff        <= skip_in;
            flags_ff       <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_symbol_ff <= req_symbol;
         s1_last_ff   <= req_last_char;
         s1_read_ff   <= req_read_length;
      end
      if (s1_move && s1_last_ff) begin
         rsp_changed_ff <= rsp_changed_in;
         rsp_trim_ff    <= rsp_trim_in;
         rsp_length_ff  <= rsp_length_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_changed    = rsp_changed_ff;
   assign rsp_trim_start = rsp_trim_ff;
   assign rsp_new_length = rsp_length_ff;

   `ASSERT_IMPLIES(a_nonfinal_flows, clock, reset, s1_valid_ff && !s1_last_ff, !req_stall)
   `ASSERT_IMPLIES(a_unchanged_no_trim, clock, reset, rsp_valid_ff && !rsp_changed_ff,
                   rsp_trim_ff == '0)
   `ASSERT_NEXT(a_final_restores, clock, reset, s1_move && s1_last_ff,
                flags_ff.at_first_char && (digit_count_ff == '0) && (aligned_ff == '0))

endmodule
`default_nettype wire

// ----- rtl/core/cigtrim_step.sv -----
`default_nettype none
module cigtrim_step #(
   parameter int LENGTH_BITS = cigtrim_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic [cigtrim_pkg::SYMBOL_BITS-1:0] symbol,
   input  logic                                last_char,
   input  logic [cigtrim_pkg::READ_BITS-1:0]   read_length,
   input  logic [LENGTH_BITS-1:0]              digit_count,
   input  logic [LENGTH_BITS-1:0]              aligned_length,
   input  logic [LENGTH_BITS-1:0]              start_skip,
   input  cigtrim_pkg::cigtrim_flags_type      flags,
   output logic [LENGTH_BITS-1:0]              digit_count_next,
   output logic [LENGTH_BITS-1:0]              aligned_length_next,
   output logic [LENGTH_BITS-1:0]              start_skip_next,
   output cigtrim_pkg::cigtrim_flags_type      flags_next,
   output logic                                changed,
   output logic [cigtrim_pkg::READ_BITS-1:0]   trim_start,
   output logic [cigtrim_pkg::READ_BITS-1:0]   new_length
);
   import cigtrim_pkg::*;

   localparam int CW = (LENGTH_BITS > READ_BITS) ? LENGTH_BITS : READ_BITS;
   localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

   logic                     is_digit;
   logic [3:0]               digit_value;
   logic [LENGTH_BITS+3:0]   digit_product;
   logic [LENGTH_BITS-1:0]   digit_sat;
   logic [LENGTH_BITS:0]     aligned_sum;
   logic [LENGTH_BITS-1:0]   aligned_sat;
   logic [LENGTH_BITS:0]     skip_sum;
   logic [LENGTH_BITS-1:0]   skip_sat;
   logic [CW-1:0]            read_ext;
   logic [LENGTH_BITS-1:0]   read_clamped;
   logic [LENGTH_BITS-1:0]   dc_upd;
   logic [LENGTH_BITS-1:0]   al_upd;
   logic [LENGTH_BITS-1:0]   ss_upd;
   cigtrim_flags_type        fl_upd;

   assign is_digit    = (symbol >= CHAR_ZERO) && (symbol <= CHAR_NINE);
   assign digit_value = 4'(symbol - CHAR_ZERO);

   // Times ten as shift-and-add; the product fits four extra bits.
   assign digit_product = ({4'b0, digit_count} << 3) + ({4'b0, digit_count} << 1)
                          + (LENGTH_BITS+4)'(digit_value);
   assign digit_sat = (digit_product[LENGTH_BITS+3:LENGTH_BITS] != 4'b0)
                      ? CNT_MAX : digit_product[LENGTH_BITS-1:0];

   assign aligned_sum = {1'b0, aligned_length} + {1'b0, digit_count};
   assign aligned_sat = aligned_sum[LENGTH_BITS] ? CNT_MAX : aligned_sum[LENGTH_BITS-1:0];
   assign skip_sum    = {1'b0, start_skip} + {1'b0, digit_count};
   assign skip_sat    = skip_sum[LENGTH_BITS] ? CNT_MAX : skip_sum[LENGTH_BITS-1:0];

   assign read_ext     = CW'(read_length);
   assign read_clamped = (read_ext > CW'(CNT_MAX)) ? CNT_MAX : LENGTH_BITS'(read_ext);

   always_comb begin
      dc_upd = digit_count;
      al_upd = aligned_length;
      ss_upd = start_skip;
      fl_upd = flags;
      fl_upd.at_first_char = 1'b0;
      if (flags.at_first_char && (symbol == CHAR_STAR)) begin
         fl_upd.star_cigar = 1'b1;
      end else if (flags.star_cigar || flags.segment_ended) begin
         // Everything after a star or after the segment end is ignored.
      end else if (is_digit) begin
         dc_upd = digit_sat;
      end else begin
         dc_upd = '0;
         if (digit_count != '0) begin
            unique case (symbol)
               CHAR_M, CHAR_I: begin
                  al_upd = aligned_sat;
               end
               CHAR_D: begin
               end
               CHAR_S: begin
                  if (aligned_length != '0) begin
                     fl_upd.segment_ended = 1'b1;
                  end else begin
                     ss_upd = skip_sat;
                  end
               end
               CHAR_H: begin
                  if (aligned_length != '0) begin
                     fl_upd.segment_ended = 1'b1;
                  end
               end
               default: begin
                  ss_upd = '0;
                  al_upd = read_clamped;
               end
            endcase
         end
      end
   end

   always_comb begin
      changed = !fl_upd.star_cigar && (al_upd != '0) && (CW'(al_upd) != read_ext);
      if (changed) begin
         trim_start = READ_BITS'(CW'(ss_upd));
         new_length = READ_BITS'(CW'(al_upd));
      end else begin
         trim_start = '0;
         new_length = read_length;
      end
   end

   // The final character of a string returns the state to its reset values.
   assign digit_count_next    = last_char ? '0 : dc_upd;
   assign aligned_length_next = last_char ? '0 : al_upd;
   assign start_skip_next     = last_char ? '0 : ss_upd;
   assign flags_next          = last_char ? FLAGS_RESET : fl_upd;

endmodule
`default_nettype wire

// ----- test/cigar_aligned_segment_trim_unit_tb.sv -----
`timescale 1ns / 100ps

module cigar_aligned_segment_trim_unit_tb;
   import cigtrim_pkg::*;

   localparam int CNT_BITS = LENGTH_BITS_DEFAULT;
   localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_Z = 8'h5A;
   localparam int RANDOM_CHARS = 1800;
   localparam int HOLD_AFTER = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [SYMBOL_BITS-1:0] sym;
      logic                   last;
      logic [READ_BITS-1:0]   rlen;
      int                     gap;
   } char_beat_type;

   typedef struct packed {
      logic                 changed;
      logic [READ_BITS-1:0] trim_start;
      logic [READ_BITS-1:0] new_length;
   } trim_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SYMBOL_BITS-1:0] req_symbol = '0;
   logic                   req_last_char = 1'b0;
   logic [READ_BITS-1:0]   req_read_length = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_changed;
   logic [READ_BITS-1:0]   rsp_trim_start;
   logic [READ_BITS-1:0]   rsp_new_length;

   char_beat_type   pending_chars[$];
   trim_result_type trim_expected[$];

   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   idle_left = 0;
   int   stall_left = 0;
   int   results_seen = 0;
   int   mismatch_count = 0;
   int   quiet_cycles = 0;
   bit   sender_quiet = 1'b0;
   bit   rsp_quiet = 1'b0;

   // Running state of the string being parsed.
   logic [CNT_BITS-1:0] cnt_digits = '0;
   logic [CNT_BITS-1:0] seg_aligned = '0;
   logic [CNT_BITS-1:0] seg_skip = '0;
   logic                seg_done = 1'b0;
   logic                first_pending = 1'b1;
   logic                star_string = 1'b0;

   cigar_aligned_segment_trim_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_symbol(req_symbol),
      .req_last_char(req_last_char),
      .req_read_length(req_read_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_changed(rsp_changed),
      .rsp_trim_start(rsp_trim_start),
      .rsp_new_length(rsp_new_length)
   );

   always #5 clock = ~clock;

   function automatic logic [CNT_BITS-1:0] sat_add(logic [CNT_BITS-1:0] a,
                                                   logic [CNT_BITS-1:0] b);
      logic [CNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_BITS] ? COUNT_MAX : s[CNT_BITS-1:0];
   endfunction

   function automatic void trim_track_char(logic [SYMBOL_BITS-1:0] sym, logic last,
                                           logic [READ_BITS-1:0] rlen);
      logic [31:0]         acc;
      logic [CNT_BITS-1:0] n;
      logic                first;
      trim_result_type     res;
      first = first_pending;
      first_pending = 1'b0;
      if (first && sym == CHAR_STAR) begin
         star_string = 1'b1;
      end else if (!star_string && !seg_done) begin
         if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
            acc = 32'(cnt_digits) * 32'd10 + 32'(sym - CHAR_ZERO);
            cnt_digits = (acc > 32'(COUNT_MAX)) ? COUNT_MAX : acc[CNT_BITS-1:0];
         end else begin
            n = cnt_digits;
            cnt_digits = '0;
            if (n != 0) begin
               case (sym)
                  CHAR_M, CHAR_I: begin
                     seg_aligned = sat_add(seg_aligned, n);
                  end
                  CHAR_D: begin
                     // Deletions take no read bases.
                  end
                  CHAR_S: begin
                     if (seg_aligned != 0) seg_done = 1'b1;
                     else seg_skip = sat_add(seg_skip, n);
                  end
                  CHAR_H: begin
                     if (seg_aligned != 0) seg_done = 1'b1;
                  end
                  default: begin
                     seg_skip = '0;
                     seg_aligned = rlen;
                  end
               endcase
            end
         end
      end
      if (last) begin
         if (!star_string && seg_aligned != 0 && seg_aligned != rlen) begin
            res.changed = 1'b1;
            res.trim_start = seg_skip[READ_BITS-1:0];
            res.new_length = seg_aligned[READ_BITS-1:0];
         end else begin
            res.changed = 1'b0;
            res.trim_start = '0;
            res.new_length = rlen;
         end
         trim_expected.push_back(res);
         cnt_digits = '0;
         seg_aligned = '0;
         seg_skip = '0;
         seg_done = 1'b0;
         first_pending = 1'b1;
         star_string = 1'b0;
      end
   endfunction

   task automatic queue_string(input string s, input logic [READ_BITS-1:0] rlen);
      char_beat_type b;
      for (int k = 0; k < s.len(); k++) begin
         if ($urandom_range(0, 15) == 0) sender_quiet = !sender_quiet;
         b.sym = s[k];
         b.last = (k == s.len() - 1);
         b.rlen = rlen;
         b.gap = sender_quiet ? 0 : $urandom_range(0, 19);
         pending_chars.push_back(b);
      end
   endtask

   function automatic string noise_chars(int count);
      string s;
      s = "";
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 2) == 0)
            s = $sformatf("%s%c", s, CHAR_ZERO + 8'($urandom_range(0, 9)));
         else
            s = $sformatf("%s%c", s, 8'($urandom_range(0, 255)));
      end
      return s;
   endfunction

   // Mostly well-formed strings with random counts; a few odd letters mixed in.
   function automatic string random_cigar(output logic [READ_BITS-1:0] rlen);
      string       s;
      string       num;
      int unsigned cnt;
      int unsigned aligned_sum;
      int          pick;
      logic [7:0]  op;
      s = "";
      aligned_sum = 0;
      for (int k = $urandom_range(1, 6); k > 0; k--) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) cnt = 0;
         else if (pick == 1) cnt = $urandom_range(0, 999999);
         else cnt = $urandom_range(1, 150);
         pick = $urandom_range(0, 19);
         if (pick < 7) op = CHAR_M;
         else if (pick < 9) op = CHAR_I;
         else if (pick < 11) op = CHAR_D;
         else if (pick < 15) op = CHAR_S;
         else if (pick < 17) op = CHAR_H;
         else if (pick < 18) op = CHAR_STAR;
         else op = 8'($urandom_range(CHAR_A, CHAR_Z));
         if (op == CHAR_M || op == CHAR_I) aligned_sum += cnt;
         num = $sformatf("%0d", cnt);
         if ($urandom_range(0, 9) == 0) num = {"0", num};
         if ($urandom_range(0, 19) == 0) num = "";
         s = $sformatf("%s%s%c", s, num, op);
      end
      if ($urandom_range(0, 9) == 0) s = $sformatf("%s%0d", s, $urandom_range(0, 99));
      case ($urandom_range(0, 2))
         0: rlen = READ_BITS'($urandom_range(0, 65535));
         1: rlen = READ_BITS'($urandom_range(0, 300));
         default: rlen = (aligned_sum > 65535) ? '1 : READ_BITS'(aligned_sum);
      endcase
      return s;
   endfunction

   initial begin
      string                s;
      logic [READ_BITS-1:0] rlen;
      int                   made;
      queue_string("*", 16'hFFFF);
      queue_string("2S3M1D4H", 16'd40);
      queue_string("0M5X", 16'hFFFF);
      queue_string("99999M", 16'd7);
      queue_string("9S2I8", 16'd3);
      made = 0;
      while (made < RANDOM_CHARS) begin
         case ($urandom_range(0, 19))
            0, 1: s = {"*", noise_chars($urandom_range(0, 5))};
            2, 3, 4: s = noise_chars($urandom_range(1, 8));
            default: s = random_cigar(rlen);
         endcase
         if (s.len() > 0 && s[0] != CHAR_STAR && $urandom_range(0, 3) == 0)
            rlen = READ_BITS'($urandom_range(0, 65535));
         else if (s.len() > 0 && (s[0] == CHAR_STAR || rlen === 'x))
            rlen = READ_BITS'($urandom_range(0, 65535));
         queue_string(s, rlen);
         made += s.len();
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_chars.size() > 0 || req_valid) @(posedge clock);
      while (trim_expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   always @(negedge clock) begin : drive_chars
      char_beat_type b;
      if (!reset && (!req_valid || req_fire)) begin
         if (idle_left > 0) begin
            req_valid <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (pending_chars.size() > 0) begin
            b = pending_chars.pop_front();
            req_valid <= 1'b1;
            req_symbol <= b.sym;
            req_last_char <= b.last;
            req_read_length <= b.rlen;
            idle_left <= b.gap;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // A long hold-off once, after enough results, lets the block back up.
   always @(negedge clock) begin : drain_results
      int wait_cycles;
      if (rsp_fire) begin
         if ($urandom_range(0, 15) == 0) rsp_quiet = !rsp_quiet;
         wait_cycles = rsp_quiet ? 0 : $urandom_range(0, 19);
         if (results_seen == HOLD_AFTER) wait_cycles = HOLD_CYCLES;
      end else begin
         wait_cycles = stall_left;
      end
      rsp_stall <= (wait_cycles > 0);
      stall_left <= (wait_cycles > 0) ? wait_cycles - 1 : 0;
   end

   always @(posedge clock) begin : check_results
      trim_result_type want;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall)
         trim_track_char(req_symbol, req_last_char, req_read_length);
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (trim_expected.size() == 0) begin
            $error("result beat with no result expected");
            mismatch_count++;
         end else begin
            want = trim_expected.pop_front();
            if (rsp_changed !== want.changed) begin
               $error("changed: expected %0d, actual %0d", want.changed, rsp_changed);
               mismatch_count++;
            end
            if (rsp_trim_start !== want.trim_start) begin
               $error("trim_start: expected %0d, actual %0d", want.trim_start,
                      rsp_trim_start);
               mismatch_count++;
            end
            if (rsp_new_length !== want.new_length) begin
               $error("new_length: expected %0d, actual %0d", want.new_length,
                      rsp_new_length);
               mismatch_count++;
            end
         end
      end
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
